@@ hdl/banded_projection_bit_hash_defines.svh @@
// Assertion macros for the banded projection bit hash.
// Used by the port checker; expects clk and rst_n in the enclosing scope.
`ifndef BANDED_PROJECTION_BIT_HASH_DEFINES_SVH
`define BANDED_PROJECTION_BIT_HASH_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define BPH_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge out of reset.
`define BPH_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/bph_pkg.sv @@
// Shared types and constants of the banded projection bit hash.
// No dependencies; used by every RTL file of the block.
`timescale 1ns / 1ps

package bph_pkg;

    // Field and register widths
    localparam int DIM_W      = 11;    // frame dimension, band size
    localparam int DIM_MAX    = 2047;  // largest value a dimension register holds
    localparam int THR_W      = 8;
    localparam int PIX_W      = 8;
    localparam int BAND_W     = 6;
    localparam int NBAND_W    = 6;     // band count register
    localparam int CNT_W      = 11;    // per-column set count
    localparam int NFLAG      = 63;    // band flags per frame
    localparam int LAST_BAND  = 62;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ROWS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd4;

    // Register reset values
    localparam int ROWS_RESET  = 180;
    localparam int COLS_RESET  = 320;
    localparam int BANDS_RESET = 18;
    localparam int THR_RESET   = 100;

    // Frame setup, latched at the first pixel of each frame
    typedef struct packed {
        logic             dir;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [THR_W-1:0] thr;
        logic [DIM_W-1:0] bsize;
    } frame_cfg_t;

    // One run of result items: flags[0] goes out with band index k,
    // then the flags shift down until k reaches last_k.
    typedef struct packed {
        logic [NFLAG-1:0]  flags;
        logic [BAND_W-1:0] k;
        logic [BAND_W-1:0] last_k;
        logic              last_en;
    } burst_t;

endpackage

@@ hdl/bph_prep.sv @@
// Configuration registers and the band size divider.
// Depends on bph_pkg; feeds the frame setup to the top level.
`timescale 1ns / 1ps

module bph_prep #(
    parameter int MAX_ROWS = 1024,
    parameter int MAX_COLS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bph_pkg::CFG_DATA_W-1:0] cfg_data,
    output bph_pkg::frame_cfg_t            next_cfg,
    output logic                           next_ok
);

    localparam int MAXR_C = (MAX_ROWS > bph_pkg::DIM_MAX) ? bph_pkg::DIM_MAX : MAX_ROWS;
    localparam int MAXC_C = (MAX_COLS > bph_pkg::DIM_MAX) ? bph_pkg::DIM_MAX : MAX_COLS;
    localparam int STEPS  = bph_pkg::DIM_W;
    localparam int STEP_W = $clog2(STEPS);

    logic                         dir_reg;
    logic [bph_pkg::DIM_W-1:0]    rows_reg;
    logic [bph_pkg::DIM_W-1:0]    cols_reg;
    logic [bph_pkg::NBAND_W-1:0]  bands_reg;
    logic [bph_pkg::THR_W-1:0]    thr_reg;

    logic                         busy_reg;
    logic                         ok_reg;
    logic [STEP_W-1:0]            step_reg;
    logic [bph_pkg::DIM_W-1:0]    quo_reg;
    logic [bph_pkg::NBAND_W-1:0]  rem_reg;
    logic [bph_pkg::DIM_W-1:0]    bsize_reg;

    logic [bph_pkg::DIM_W-1:0]    rows_c;
    logic [bph_pkg::DIM_W-1:0]    cols_c;
    logic [bph_pkg::DIM_W-1:0]    lines;
    logic [bph_pkg::NBAND_W-1:0]  divisor;
    logic [bph_pkg::NBAND_W:0]    trial;
    logic                         trial_ge;
    logic [bph_pkg::NBAND_W-1:0]  rem_next;
    logic [bph_pkg::DIM_W-1:0]    quo_next;

    // zero becomes one, oversize saturates
    function automatic logic [bph_pkg::DIM_W-1:0] clamp_dim(
        input logic [bph_pkg::DIM_W-1:0] v,
        input logic [bph_pkg::DIM_W-1:0] maxv
    );
        logic [bph_pkg::DIM_W-1:0] r;
        if (v == '0)
            r = bph_pkg::DIM_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    assign rows_c  = clamp_dim(rows_reg, bph_pkg::DIM_W'(MAXR_C));
    assign cols_c  = clamp_dim(cols_reg, bph_pkg::DIM_W'(MAXC_C));
    assign lines   = dir_reg ? cols_c : rows_c;
    assign divisor = (bands_reg == '0) ? bph_pkg::NBAND_W'(1) : bands_reg;

    // one restoring division step per cycle
    assign trial    = {rem_reg, quo_reg[bph_pkg::DIM_W-1]};
    assign trial_ge = trial >= {1'b0, divisor};
    assign rem_next = trial_ge ? bph_pkg::NBAND_W'(trial - {1'b0, divisor})
                               : trial[bph_pkg::NBAND_W-1:0];
    assign quo_next = {quo_reg[bph_pkg::DIM_W-2:0], trial_ge};

    // registers, divider control; any write restarts the division
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg   <= 1'b0;
            rows_reg  <= bph_pkg::DIM_W'(bph_pkg::ROWS_RESET);
            cols_reg  <= bph_pkg::DIM_W'(bph_pkg::COLS_RESET);
            bands_reg <= bph_pkg::NBAND_W'(bph_pkg::BANDS_RESET);
            thr_reg   <= bph_pkg::THR_W'(bph_pkg::THR_RESET);
            busy_reg  <= 1'b0;
            ok_reg    <= 1'b0;
            step_reg  <= '0;
            quo_reg   <= '0;
            rem_reg   <= '0;
            bsize_reg <= bph_pkg::DIM_W'(1);
        end
        else if (cfg_write)
        begin
            busy_reg <= 1'b0;
            ok_reg   <= 1'b0;
            case (cfg_index)
                bph_pkg::CFG_DIRECTION:  dir_reg   <= cfg_data[0];
                bph_pkg::CFG_FRAME_ROWS: rows_reg  <= cfg_data;
                bph_pkg::CFG_FRAME_COLS: cols_reg  <= cfg_data;
                bph_pkg::CFG_BAND_COUNT: bands_reg <= cfg_data[bph_pkg::NBAND_W-1:0];
                bph_pkg::CFG_THRESHOLD:  thr_reg   <= cfg_data[bph_pkg::THR_W-1:0];
                default: ;
            endcase
        end
        else if (!ok_reg && !busy_reg)
        begin
            busy_reg <= 1'b1;
            quo_reg  <= lines;
            rem_reg  <= '0;
            step_reg <= STEP_W'(STEPS - 1);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            if (step_reg == '0)
            begin
                busy_reg  <= 1'b0;
                ok_reg    <= 1'b1;
                bsize_reg <= (quo_next == '0) ? bph_pkg::DIM_W'(1) : quo_next;
            end
            else
            begin
                step_reg <= step_reg - STEP_W'(1);
            end
        end
    end

    assign next_cfg.dir   = dir_reg;
    assign next_cfg.rows  = rows_c;
    assign next_cfg.cols  = cols_c;
    assign next_cfg.thr   = thr_reg;
    assign next_cfg.bsize = bsize_reg;
    assign next_ok        = ok_reg;

endmodule

@@ hdl/bph_colmem.sv @@
// Per-column set counters: a synchronous RAM with read-modify-write.
// Depends on bph_pkg; forwards the last write to a read of the same column.
`timescale 1ns / 1ps

module bph_colmem #(
    parameter int DEPTH = 1024
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      rd_valid,
    input  logic [$clog2(DEPTH)-1:0]  rd_addr,
    input  logic                      rd_clear,
    input  logic                      rd_hit,
    output logic [bph_pkg::CNT_W-1:0] cnt_new
);

    localparam int AW = $clog2(DEPTH);

    logic [bph_pkg::CNT_W-1:0] mem [DEPTH];

    logic                      b_valid_reg;
    logic [AW-1:0]             b_addr_reg;
    logic                      b_clear_reg;
    logic                      b_hit_reg;
    logic [bph_pkg::CNT_W-1:0] rdata_reg;
    logic                      fwd_sel_reg;
    logic                      fwd_sel_next;
    logic [bph_pkg::CNT_W-1:0] fwd_data_reg;
    logic [bph_pkg::CNT_W-1:0] old_cnt;

    // old count: RAM data, or the value written in the read cycle
    assign old_cnt = fwd_sel_reg ? fwd_data_reg : rdata_reg;
    assign cnt_new = b_clear_reg ? bph_pkg::CNT_W'(b_hit_reg)
                                 : old_cnt + bph_pkg::CNT_W'(b_hit_reg);

    assign fwd_sel_next = rd_valid && b_valid_reg && (rd_addr == b_addr_reg);

    // RAM: read in the request cycle, write back in the cycle after
    always_ff @(posedge clk)
    begin
        if (rd_valid)
            rdata_reg <= mem[rd_addr];
        if (b_valid_reg)
            mem[b_addr_reg] <= cnt_new;
        b_addr_reg   <= rd_addr;
        b_clear_reg  <= rd_clear;
        b_hit_reg    <= rd_hit;
        fwd_data_reg <= cnt_new;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            fwd_sel_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= rd_valid;
            fwd_sel_reg <= fwd_sel_next;
        end
    end

endmodule

@@ hdl/bph_emit.sv @@
// Result queue: two runs of hash bits, sent one item per cycle while out_ready is high.
// Depends on bph_pkg; the top level grants input by the fill count.
`timescale 1ns / 1ps

module bph_emit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  bph_pkg::burst_t            push_data,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic                       hash_bit,
    output logic [bph_pkg::BAND_W-1:0] band_index,
    output logic                       last,
    output logic [1:0]                 fill,
    output logic                       retire
);

    bph_pkg::burst_t q0_reg;
    bph_pkg::burst_t q1_reg;
    bph_pkg::burst_t q0_adv;
    logic [1:0]      fill_reg;
    logic [1:0]      fill_next;
    logic            take;
    logic            at_end;

    assign out_valid  = fill_reg != 2'd0;
    assign hash_bit   = q0_reg.flags[0];
    assign band_index = q0_reg.k;
    assign at_end     = q0_reg.k == q0_reg.last_k;
    assign last       = q0_reg.last_en && at_end;
    assign take       = out_valid && out_ready;
    assign retire     = take && at_end;
    assign fill       = fill_reg;

    // head run after one item leaves
    always_comb
    begin
        q0_adv       = q0_reg;
        q0_adv.flags = q0_reg.flags >> 1;
        q0_adv.k     = q0_reg.k + bph_pkg::BAND_W'(1);
    end

    assign fill_next = fill_reg - 2'(retire) + 2'(push);

    // queue entries
    always_ff @(posedge clk)
    begin
        if (retire)
        begin
            if (fill_reg == 2'd2)
                q0_reg <= q1_reg;
            else if (push)
                q0_reg <= push_data;
        end
        else
        begin
            if (take)
                q0_reg <= q0_adv;
            if (push)
            begin
                if (fill_reg == 2'd0)
                    q0_reg <= push_data;
                else
                    q1_reg <= push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_reg <= 2'd0;
        else
            fill_reg <= fill_next;
    end

endmodule

@@ hdl/banded_projection_bit_hash.sv @@
// Top level of the banded projection bit hash.
// Depends on bph_pkg, bph_prep, bph_colmem and bph_emit.
`timescale 1ns / 1ps

//  channel  | handshake                | payload
//  ---------+--------------------------+--------------------------------
//  config   | cfg_write                | cfg_index, cfg_data
//  input    | in_valid / in_ready      | pixel
//  output   | out_valid / out_ready    | hash_bit, band_index, last
//
//  One pixel per cycle while in_ready is high; each result is registered in the
//  second stage and the result queue. After reset and any config write, the band
//  size divider runs again; the first pixel of a frame waits for it, others do not.
//  A column-mode frame ends in a run of up to 63 items, one per cycle at the output
//  while out_ready is high. Past the divider wait, in_ready drops only when the
//  two-run result queue could overflow. Reset clears all control state; the column
//  counter RAM needs no clearing, row 0 of each frame writes it before any read.

module banded_projection_bit_hash #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [bph_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bph_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bph_pkg::PIX_W-1:0]      pixel,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           hash_bit,
    output logic [bph_pkg::BAND_W-1:0]     band_index,
    output logic                           last
);

    localparam int MAXR_C = (MAX_ROWS > bph_pkg::DIM_MAX) ? bph_pkg::DIM_MAX : MAX_ROWS;
    localparam int MAXC_C = (MAX_COLS > bph_pkg::DIM_MAX) ? bph_pkg::DIM_MAX : MAX_COLS;
    localparam int RW     = $clog2(MAXR_C);
    localparam int CW     = $clog2(MAXC_C);
    localparam int DW     = bph_pkg::DIM_W;
    localparam int BW     = bph_pkg::BAND_W;
    localparam logic [BW-1:0] LAST_B = BW'(bph_pkg::LAST_BAND);

    bph_pkg::frame_cfg_t next_cfg;
    bph_pkg::frame_cfg_t cur_reg;
    bph_pkg::frame_cfg_t eff;
    logic                next_ok;

    // position and band tracking
    logic [RW-1:0]  row_pos_reg;
    logic [CW-1:0]  col_pos_reg;
    logic [DW-1:0]  row_cnt_reg;
    logic [DW-1:0]  rp_reg;
    logic [BW-1:0]  rb_reg;
    logic           bflag_reg;
    logic [DW-1:0]  cp_reg;
    logic [BW-1:0]  cb_reg;
    logic [bph_pkg::NFLAG-1:0] cflags_reg;
    logic [bph_pkg::NFLAG-1:0] cflags_next;
    logic [bph_pkg::NFLAG-1:0] flags_upd;

    // second stage
    logic           b_res_reg;
    logic           b_dir_reg;
    logic           b_colchk_reg;
    logic [BW-1:0]  b_cband_reg;
    logic           b_row_flag_reg;
    logic [BW-1:0]  b_row_band_reg;
    logic           b_row_last_reg;

    logic           fs;
    logic           acc;
    logic           hit;
    logic           col_zero;
    logic           last_col;
    logic           last_row;
    logic [DW-1:0]  bs_m1;
    logic [DW-1:0]  rc_new;
    logic           full_row;
    logic [DW-1:0]  rp_e;
    logic [BW-1:0]  rb_e;
    logic           flag_e;
    logic           row_flag;
    logic           row_wrap;
    logic           row_res;
    logic           col_res;
    logic [DW-1:0]  cp_e;
    logic [BW-1:0]  cb_e;
    logic           col_wrap;
    logic [bph_pkg::CNT_W-1:0] cnt_new;
    logic           col_bit;
    logic           credit_ok;
    logic [1:0]     fill;
    logic           retire;
    logic           push;
    bph_pkg::burst_t push_data;

    bph_prep #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .next_cfg  (next_cfg),
        .next_ok   (next_ok)
    );

    // frame setup: new values take over at the frame's first pixel
    assign fs  = (row_pos_reg == '0) && (col_pos_reg == '0);
    assign eff = fs ? next_cfg : cur_reg;

    assign bs_m1    = eff.bsize - DW'(1);
    assign col_zero = col_pos_reg == '0;
    assign last_col = (DW'(col_pos_reg) + DW'(1)) == eff.cols;
    assign last_row = (DW'(row_pos_reg) + DW'(1)) == eff.rows;
    assign hit      = pixel > eff.thr;

    // row mode: set count of the row, band flag, band boundary
    assign rc_new   = col_zero ? DW'(hit) : row_cnt_reg + DW'(hit);
    assign full_row = rc_new > (eff.cols >> 1);
    assign rp_e     = fs ? '0 : rp_reg;
    assign rb_e     = fs ? '0 : rb_reg;
    assign flag_e   = fs ? 1'b0 : bflag_reg;
    assign row_flag = flag_e | full_row;
    assign row_wrap = rp_e == bs_m1;
    assign row_res  = !eff.dir && last_col && (last_row || (row_wrap && rb_e != LAST_B));

    // column mode: band of the current column
    assign cp_e     = col_zero ? '0 : cp_reg;
    assign cb_e     = col_zero ? '0 : cb_reg;
    assign col_wrap = cp_e == bs_m1;
    assign col_res  = eff.dir && last_col && last_row;

    // queue room: entries plus a pending push, less a run leaving now
    assign credit_ok = ({1'b0, fill} + {2'b0, b_res_reg}) <= (3'd1 + {2'b0, retire});
    assign in_ready  = (!fs || next_ok) && credit_ok;
    assign acc       = in_valid && in_ready;

    bph_colmem #(
        .DEPTH (MAXC_C)
    ) u_colmem (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_valid (acc && eff.dir),
        .rd_addr  (col_pos_reg),
        .rd_clear (row_pos_reg == '0),
        .rd_hit   (hit),
        .cnt_new  (cnt_new)
    );

    // second stage: column majority on the last row, result push
    assign col_bit   = b_colchk_reg && (cnt_new > bph_pkg::CNT_W'(cur_reg.rows >> 1));
    assign flags_upd = cflags_reg
                     | (col_bit ? (bph_pkg::NFLAG'(1) << b_cband_reg) : '0);
    assign cflags_next = (acc && fs) ? '0 : flags_upd;
    assign push      = b_res_reg;

    always_comb
    begin
        if (b_dir_reg)
        begin
            push_data.flags   = flags_upd;
            push_data.k       = '0;
            push_data.last_k  = b_cband_reg;
            push_data.last_en = 1'b1;
        end
        else
        begin
            push_data.flags   = bph_pkg::NFLAG'(b_row_flag_reg);
            push_data.k       = b_row_band_reg;
            push_data.last_k  = b_row_band_reg;
            push_data.last_en = b_row_last_reg;
        end
    end

    // pipeline and tracking registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg.dir    <= 1'b0;
            cur_reg.rows   <= DW'(1);
            cur_reg.cols   <= DW'(1);
            cur_reg.thr    <= bph_pkg::THR_W'(bph_pkg::THR_RESET);
            cur_reg.bsize  <= DW'(1);
            row_pos_reg    <= '0;
            col_pos_reg    <= '0;
            row_cnt_reg    <= '0;
            rp_reg         <= '0;
            rb_reg         <= '0;
            bflag_reg      <= 1'b0;
            cp_reg         <= '0;
            cb_reg         <= '0;
            cflags_reg     <= '0;
            b_res_reg      <= 1'b0;
            b_dir_reg      <= 1'b0;
            b_colchk_reg   <= 1'b0;
            b_cband_reg    <= '0;
            b_row_flag_reg <= 1'b0;
            b_row_band_reg <= '0;
            b_row_last_reg <= 1'b0;
        end
        else
        begin
            cflags_reg   <= cflags_next;
            b_res_reg    <= acc && (row_res || col_res);
            b_colchk_reg <= acc && eff.dir && last_row;
            if (acc)
            begin
                cur_reg        <= eff;
                row_cnt_reg    <= rc_new;
                b_dir_reg      <= eff.dir;
                b_cband_reg    <= cb_e;
                b_row_flag_reg <= row_flag;
                b_row_band_reg <= rb_e;
                b_row_last_reg <= last_row;
                if (last_col)
                begin
                    col_pos_reg <= '0;
                    row_pos_reg <= last_row ? '0 : row_pos_reg + RW'(1);
                    bflag_reg   <= row_res ? 1'b0 : row_flag;
                    rp_reg      <= row_wrap ? '0 : rp_e + DW'(1);
                    rb_reg      <= (row_wrap && rb_e != LAST_B) ? rb_e + BW'(1) : rb_e;
                    cp_reg      <= '0;
                    cb_reg      <= '0;
                end
                else
                begin
                    col_pos_reg <= col_pos_reg + CW'(1);
                    bflag_reg   <= flag_e;
                    rp_reg      <= rp_e;
                    rb_reg      <= rb_e;
                    cp_reg      <= col_wrap ? '0 : cp_e + DW'(1);
                    cb_reg      <= (col_wrap && cb_e != LAST_B) ? cb_e + BW'(1) : cb_e;
                end
            end
        end
    end

    bph_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .hash_bit   (hash_bit),
        .band_index (band_index),
        .last       (last),
        .fill       (fill),
        .retire     (retire)
    );

endmodule

@@ hdl/bph_check.sv @@
// Port checker for the banded projection bit hash, bound to the top level.
// Depends on bph_pkg and banded_projection_bit_hash_defines.svh.
`timescale 1ns / 1ps
`include "banded_projection_bit_hash_defines.svh"

module bph_check (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       hash_bit,
    input logic [bph_pkg::BAND_W-1:0] band_index,
    input logic                       last
);

    logic [bph_pkg::BAND_W-1:0] exp_idx_reg;

    // band index the next item must carry: zero after the frame's last bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            exp_idx_reg <= '0;
        else if (out_valid && out_ready)
            exp_idx_reg <= last ? '0 : band_index + bph_pkg::BAND_W'(1);
    end

    // a stalled result item holds
    `BPH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hash_bit) && $stable(band_index) && $stable(last), "result item changed while stalled")

    // bands of a frame come out in order, without gaps
    `BPH_ASSERT_NOW(a_band_order, out_valid, band_index == exp_idx_reg, "band index out of sequence")

    // band index never passes the saturated band
    `BPH_ASSERT_NOW(a_band_range, out_valid, band_index <= bph_pkg::BAND_W'(bph_pkg::LAST_BAND), "band index beyond last band")

endmodule

bind banded_projection_bit_hash bph_check u_bph_check (.*);
